// File: hw/rtl/lsc_pkg.sv
`default_nettype none

package lsc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 8;
  localparam int CODE_WIDTH = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [CODE_WIDTH-1:0] outcode_t;

  // outcode bits
  localparam outcode_t CODE_LEFT   = 4'b0001;
  localparam outcode_t CODE_RIGHT  = 4'b0010;
  localparam outcode_t CODE_BOTTOM = 4'b0100;
  localparam outcode_t CODE_TOP    = 4'b1000;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_X_MIN = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_X_MAX = 8'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_Y_MIN = 8'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_Y_MAX = 8'd3;

  // window after reset
  localparam coord_t RST_X_MIN = 16'sd4;
  localparam coord_t RST_X_MAX = 16'sd10;
  localparam coord_t RST_Y_MIN = 16'sd4;
  localparam coord_t RST_Y_MAX = 16'sd8;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_req_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/line_segment_clipper_core.sv
`default_nettype none

// channel   direction  signals                               request
// in        input      in_valid, in_ready, in_req            one segment, two endpoints
// out       output     out_valid, out_ready, out_res         accept flag, clipped endpoints
// cfg       input      cfg_valid, cfg_ready, cfg_index/data  one window edge register write
//
// one segment takes at most MAX_PASSES clip passes; each pass goes through the
// code, setup, multiply, divide and update states, using the shared
// multiplier and the restoring divider, which retires one quotient bit a cycle
// rst_n is synchronous: window returns to x 4..10, y 4..8, sequencer idles
// in_ready is high only while the sequencer idles; a finished result waits
// in the output register, and a stalled out_ready holds the sequencer in done

module line_segment_clipper_core #(
  parameter int MAX_PASSES = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire lsc_pkg::in_req_t          in_req,
  output logic                           out_valid,
  input  wire                            out_ready,
  output lsc_pkg::out_res_t              out_res,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [lsc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire [lsc_pkg::COORD_WIDTH-1:0] cfg_data
);
  import lsc_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int PASS_W = $clog2(MAX_PASSES + 1);
  localparam int CNT_W  = $clog2(W);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CODE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  coord_t            x_min_r, x_max_r, y_min_r, y_max_r;
  coord_t            ax_r, ay_r, bx_r, by_r;
  outcode_t          ca_r, cb_r;
  logic [PASS_W-1:0] pass_r;
  logic              acc_r;
  logic              move_a_r;     // first endpoint is the one moved
  logic              x_axis_r;     // clipping against a vertical edge
  logic              neg_r;
  coord_t            edge_r, base_r;
  logic [W-1:0]      mag0_r, mag1_r, magd_r;
  logic [W-1:0]      rem_r, lo_r;  // remainder and dividend/quotient shifter
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  out_res_t          out_r;

  // outcodes of the current endpoints
  outcode_t ca, cb;
  always_comb begin
    ca = '0;
    cb = '0;
    if (ax_r > x_max_r) ca = ca | CODE_RIGHT;
    if (ax_r < x_min_r) ca = ca | CODE_LEFT;
    if (ay_r > y_max_r) ca = ca | CODE_TOP;
    if (ay_r < y_min_r) ca = ca | CODE_BOTTOM;
    if (bx_r > x_max_r) cb = cb | CODE_RIGHT;
    if (bx_r < x_min_r) cb = cb | CODE_LEFT;
    if (by_r > y_max_r) cb = cb | CODE_TOP;
    if (by_r < y_min_r) cb = cb | CODE_BOTTOM;
  end

  // pass setup: pick edge and form the three differences
  outcode_t                c_sel;
  logic                    x_axis;
  coord_t                  edge_v;
  logic signed [W:0]       d0, d1, dd;
  logic signed [W:0]       a0, a1, ad;
  always_comb begin
    c_sel  = (ca_r != '0) ? ca_r : cb_r;
    x_axis = ((c_sel & (CODE_LEFT | CODE_RIGHT)) != '0);
    if ((c_sel & CODE_LEFT) != '0) begin
      edge_v = x_min_r;
    end else if ((c_sel & CODE_RIGHT) != '0) begin
      edge_v = x_max_r;
    end else if ((c_sel & CODE_BOTTOM) != '0) begin
      edge_v = y_min_r;
    end else begin
      edge_v = y_max_r;
    end
    if (x_axis) begin
      d0 = {edge_v[W-1], edge_v} - {ax_r[W-1], ax_r};
      d1 = {ay_r[W-1], ay_r} - {by_r[W-1], by_r};
      dd = {ax_r[W-1], ax_r} - {bx_r[W-1], bx_r};
    end else begin
      d0 = {edge_v[W-1], edge_v} - {ay_r[W-1], ay_r};
      d1 = {ax_r[W-1], ax_r} - {bx_r[W-1], bx_r};
      dd = {ay_r[W-1], ay_r} - {by_r[W-1], by_r};
    end
    a0 = d0[W] ? -d0 : d0;
    a1 = d1[W] ? -d1 : d1;
    ad = dd[W] ? -dd : dd;
  end

  // one restoring divide step
  logic [W:0]   div_t, div_sub;
  logic         div_ge;
  always_comb begin
    div_t   = {rem_r, lo_r[W-1]};
    div_ge  = (div_t >= {1'b0, magd_r});
    div_sub = div_t - {1'b0, magd_r};
  end

  // intercept from the quotient; a zero divisor yields zero
  logic [W-1:0] quot;
  coord_t       newv;
  always_comb begin
    quot = (magd_r == '0) ? '0 : lo_r;
    newv = neg_r ? coord_t'(base_r - coord_t'(quot)) : coord_t'(base_r + coord_t'(quot));
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CODE;
      end
      S_CODE: begin
        if (ca == '0 && cb == '0) begin
          state_nxt = S_DONE;
        end else if ((ca & cb) != '0) begin
          state_nxt = S_DONE;
        end else if (pass_r == PASS_W'(MAX_PASSES)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == CNT_W'(W - 1)) state_nxt = S_UPD;
      end
      S_UPD: state_nxt = S_CODE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_min_r     <= RST_X_MIN;
      x_max_r     <= RST_X_MAX;
      y_min_r     <= RST_Y_MIN;
      y_max_r     <= RST_Y_MAX;
      pass_r      <= '0;
      cnt_r       <= '0;
      acc_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // window register writes, unknown indexes dropped
      if (cfg_valid) begin
        case (cfg_index)
          CFG_X_MIN: x_min_r <= coord_t'(cfg_data);
          CFG_X_MAX: x_max_r <= coord_t'(cfg_data);
          CFG_Y_MIN: y_min_r <= coord_t'(cfg_data);
          CFG_Y_MAX: y_max_r <= coord_t'(cfg_data);
          default: ;
        endcase
      end

      // result register: refilled from done, emptied when taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          pass_r <= '0;
          acc_r  <= 1'b0;
        end
        S_CODE: begin
          if (ca == '0 && cb == '0) acc_r <= 1'b1;
        end
        S_SETUP: cnt_r <= '0;
        S_DIV:   cnt_r <= cnt_r + CNT_W'(1);
        S_UPD:   pass_r <= pass_r + PASS_W'(1);
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ax_r <= in_req.start_x;
        ay_r <= in_req.start_y;
        bx_r <= in_req.end_x;
        by_r <= in_req.end_y;
      end
      S_CODE: begin
        ca_r <= ca;
        cb_r <= cb;
      end
      S_SETUP: begin
        move_a_r <= (ca_r != '0);
        x_axis_r <= x_axis;
        edge_r   <= edge_v;
        base_r   <= x_axis ? ay_r : ax_r;
        mag0_r   <= a0[W-1:0];
        mag1_r   <= a1[W-1:0];
        magd_r   <= ad[W-1:0];
        neg_r    <= d0[W] ^ d1[W] ^ dd[W];
      end
      S_MUL: begin
        {rem_r, lo_r} <= mag0_r * mag1_r;
      end
      S_DIV: begin
        rem_r <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
        lo_r  <= {lo_r[W-2:0], div_ge};
      end
      S_UPD: begin
        if (move_a_r) begin
          ax_r <= x_axis_r ? edge_r : newv;
          ay_r <= x_axis_r ? newv : edge_r;
        end else begin
          bx_r <= x_axis_r ? edge_r : newv;
          by_r <= x_axis_r ? newv : edge_r;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_r.accepted     <= acc_r;
          out_r.clip_start_x <= acc_r ? ax_r : '0;
          out_r.clip_start_y <= acc_r ? ay_r : '0;
          out_r.clip_end_x   <= acc_r ? bx_r : '0;
          out_r.clip_end_y   <= acc_r ? by_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import lsc_pkg::*;

  localparam int CLIP_PASSES = 4;
  // one segment: setup plus up to CLIP_PASSES clip passes
  localparam int ITEM_CYCLES = 3 + 20 * CLIP_PASSES;
  localparam int DRAIN_CYCLES = 2 * ITEM_CYCLES;
  localparam int MAX_STALL = 24;
  localparam int MAX_GAP = 20;
  // cycles with no request moving on any channel before the run is called hung
  localparam int IDLE_LIMIT = 4 * (DRAIN_CYCLES + ITEM_CYCLES + MAX_STALL + MAX_GAP);
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 80;
  localparam longint COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;
  localparam longint COORD_MIN = -(2 ** (COORD_WIDTH - 1));
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BAD_INDEX = '1;

  typedef enum {SINK_OPEN, SINK_STALL, SINK_JITTER} sink_mode_t;

  // expected clipped segments, oldest first, plus a private copy of the window
  class clip_scoreboard;
    coord_t x_min, x_max, y_min, y_max;
    out_res_t clipped_q[$];
    int errors;

    function new();
      x_min = RST_X_MIN;
      x_max = RST_X_MAX;
      y_min = RST_Y_MIN;
      y_max = RST_Y_MAX;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] data);
      case (idx)
        CFG_X_MIN: x_min = data;
        CFG_X_MAX: x_max = data;
        CFG_Y_MIN: y_min = data;
        CFG_Y_MAX: y_max = data;
        default: ;
      endcase
    endfunction

    // inverted window: both bits of an axis may be set
    function outcode_t region(longint x, longint y);
      outcode_t c;
      c = '0;
      if (x < x_min) c |= CODE_LEFT;
      if (x > x_max) c |= CODE_RIGHT;
      if (y < y_min) c |= CODE_BOTTOM;
      if (y > y_max) c |= CODE_TOP;
      return c;
    endfunction

    // exact product, quotient truncated toward zero
    function longint intercept(longint num, longint mul, longint den);
      if (den == 0) return 0;
      return (num * mul) / den;
    endfunction

    function out_res_t clip_segment(in_req_t s);
      longint ax, ay, bx, by, nx, ny;
      outcode_t ca, cb, c;
      bit keep;
      out_res_t r;
      ax = $signed(s.start_x);
      ay = $signed(s.start_y);
      bx = $signed(s.end_x);
      by = $signed(s.end_y);
      keep = 1'b0;
      for (int moves = 0; moves <= CLIP_PASSES; moves++) begin
        ca = region(ax, ay);
        cb = region(bx, by);
        if (ca == '0 && cb == '0) begin
          keep = 1'b1;
          break;
        end
        if ((ca & cb) != '0) break;
        // still unsettled after the last pass: rejected
        if (moves == CLIP_PASSES) break;
        c = (ca != '0) ? ca : cb;
        if ((c & (CODE_LEFT | CODE_RIGHT)) != '0) begin
          nx = ((c & CODE_LEFT) != '0) ? x_min : x_max;
          ny = ay + intercept(nx - ax, ay - by, ax - bx);
        end else begin
          ny = ((c & CODE_BOTTOM) != '0) ? y_min : y_max;
          nx = ax + intercept(ny - ay, ax - bx, ay - by);
        end
        if (ca != '0) begin
          ax = nx;
          ay = ny;
        end else begin
          bx = nx;
          by = ny;
        end
      end
      r = '0;
      r.accepted = keep;
      if (keep) begin
        r.clip_start_x = coord_t'(ax);
        r.clip_start_y = coord_t'(ay);
        r.clip_end_x = coord_t'(bx);
        r.clip_end_y = coord_t'(by);
      end
      return r;
    endfunction

    function void note_segment(in_req_t s);
      clipped_q.push_back(clip_segment(s));
    endfunction

    function int pending();
      return clipped_q.size();
    endfunction

    function void compare(string what, longint want, longint got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (clipped_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = clipped_q.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("clip_start_x", $signed(want.clip_start_x), $signed(got.clip_start_x));
      compare("clip_start_y", $signed(want.clip_start_y), $signed(got.clip_start_y));
      compare("clip_end_x", $signed(want.clip_end_x), $signed(got.clip_end_x));
      compare("clip_end_y", $signed(want.clip_end_y), $signed(got.clip_end_y));
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  clip_scoreboard sb = new();
  int idle_cycles = 0;

  // window as last programmed, used only to aim the random segments
  coord_t win_x_lo = RST_X_MIN;
  coord_t win_x_hi = RST_X_MAX;
  coord_t win_y_lo = RST_Y_MIN;
  coord_t win_y_hi = RST_Y_MAX;

  line_segment_clipper_core #(.MAX_PASSES(CLIP_PASSES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(out_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // everything is driven at the rising edge, so at the falling edge all handshake
  // signals are settled: a channel with valid and ready high here moves a request
  // at the next rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_segment(in_req);
      if (out_valid && out_ready) sb.check_result(out_res);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: open stretches, hard stalls and cycle-by-cycle jitter
  initial begin : result_sink
    int run_left;
    sink_mode_t mode;
    run_left = 0;
    mode = SINK_OPEN;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        case ($urandom_range(3))
          0: mode = SINK_OPEN;
          1: mode = SINK_STALL;
          default: mode = SINK_JITTER;
        endcase
        run_left = (mode == SINK_STALL) ? $urandom_range(1, MAX_STALL) : $urandom_range(5, 40);
      end
      run_left--;
      case (mode)
        SINK_OPEN: out_ready <= 1'b1;
        SINK_STALL: out_ready <= 1'b0;
        default: out_ready <= ($urandom_range(1) == 1);
      endcase
    end
  end

  // leaves in_valid high; the caller lowers it when a gap follows
  task automatic send_segment(in_req_t seg_req);
    in_req <= seg_req;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // only called with the block idle; an optional stray write to an unused index
  // must leave the window alone
  task automatic write_window(coord_t xl, coord_t xh, coord_t yl, coord_t yh,
                              bit stray, logic [CFG_IDX_WIDTH-1:0] stray_idx);
    cfg_write(CFG_X_MIN, xl);
    cfg_write(CFG_X_MAX, xh);
    cfg_write(CFG_Y_MIN, yl);
    cfg_write(CFG_Y_MAX, yh);
    if (stray) cfg_write(stray_idx, coord_t'($urandom));
    cfg_valid <= 1'b0;
    win_x_lo = xl;
    win_x_hi = xh;
    win_y_lo = yl;
    win_y_hi = yh;
  endtask

  // stop sending, let every result come back, then give the block time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic coord_t spread(int span);
    return clamp_coord(longint'($urandom_range(2 * span)) - span);
  endfunction

  // mostly near the window, sometimes on or just beside an edge, sometimes anywhere
  function automatic coord_t pick_coord(coord_t a, coord_t b, int span);
    longint lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return clamp_coord(lo - 1);
          1: return clamp_coord(lo);
          2: return clamp_coord(hi);
          default: return clamp_coord(hi + 1);
        endcase
      end
      1: return coord_t'($urandom);
      default: return clamp_coord(lo - span + longint'($urandom_range(32'(hi - lo + 2 * span))));
    endcase
  endfunction

  function automatic in_req_t make_segment(int span);
    in_req_t s;
    s.start_x = pick_coord(win_x_lo, win_x_hi, span);
    s.start_y = pick_coord(win_y_lo, win_y_hi, span);
    s.end_x = pick_coord(win_x_lo, win_x_hi, span);
    s.end_y = pick_coord(win_y_lo, win_y_hi, span);
    return s;
  endfunction

  function automatic in_req_t seg(int ax, int ay, int bx, int by);
    in_req_t s;
    s.start_x = coord_t'(ax);
    s.start_y = coord_t'(ay);
    s.end_x = coord_t'(bx);
    s.end_y = coord_t'(by);
    return s;
  endfunction

  task automatic directed_checks();
    // reset window x 4..10, y 4..8
    send_segment(seg(5, 5, 9, 7));          // inside
    send_segment(seg(0, 5, 2, 7));          // both left
    send_segment(seg(-5, 6, 20, 6));        // crosses left and right
    send_segment(seg(7, -3, 7, 30));        // vertical, crosses bottom and top
    send_segment(seg(0, 0, 14, 12));        // diagonal, several passes
    send_segment(seg(0, 7, 6, 12));         // misses the corner after one move
    send_segment(seg(6, 6, 6, 6));          // single point inside
    send_segment(seg(4, 8, 4, 8));          // single point on the corner
    send_segment(seg(-32768, -32768, 32767, 32767));
    send_segment(seg(32767, -32768, -32768, 32767));
    send_segment(seg(5, 5, 50, 5));         // only the end point moves
    send_segment(seg(-7, -3, 11, 12));      // intercept truncates toward zero
    settle();
    // unused register index: window stays as it was
    write_window(RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX, 1'b1, CFG_BAD_INDEX);
    send_segment(seg(5, 5, 9, 7));
    send_segment(seg(11, 9, 30, 30));
    settle();
    // window spanning the whole coordinate range
    write_window(coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MIN),
                 coord_t'(COORD_MAX), 1'b0, CFG_BAD_INDEX);
    send_segment(seg(-32768, 32767, 32767, -32768));
    send_segment(seg(0, 0, 0, 0));
    settle();
    // window shrunk to one point
    write_window(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, CFG_BAD_INDEX);
    send_segment(seg(-5, -5, 5, 5));
    send_segment(seg(-5, -4, 5, 5));
    settle();
    // inverted on both axes, points carry both bits of an axis
    write_window(coord_t'(10), coord_t'(4), coord_t'(8), coord_t'(4), 1'b0, CFG_BAD_INDEX);
    send_segment(seg(7, 6, 8, 6));
    send_segment(seg(0, 20, 20, 0));
    send_segment(seg(0, 0, 20, 20));
    settle();
  endtask

  task automatic random_phase(int ph);
    int scale;
    int sent;
    int burst;
    int gap;
    bit hold;
    coord_t x1, x2, y1, y2, xl, xh, yl, yh;
    settle();
    case ($urandom_range(3))
      0: scale = 16;
      1: scale = 64;
      2: scale = 1024;
      default: scale = 32768;
    endcase
    x1 = spread(scale);
    x2 = spread(scale);
    y1 = spread(scale);
    y2 = spread(scale);
    xl = (x1 < x2) ? x1 : x2;
    xh = (x1 < x2) ? x2 : x1;
    yl = (y1 < y2) ? y1 : y2;
    yh = (y1 < y2) ? y2 : y1;
    case (ph)
      0: begin
        xl = coord_t'(COORD_MIN);
        xh = coord_t'(COORD_MAX);
        yl = coord_t'(COORD_MIN);
        yh = coord_t'(COORD_MAX);
      end
      1: begin
        // inverted on both axes
        {xl, xh} = {xh, xl};
        {yl, yh} = {yh, yl};
      end
      2: begin
        xh = xl;
        yh = yl;
      end
      default: begin
        // now and then the x axis inverted
        if ($urandom_range(4) == 0) {xl, xh} = {xh, xl};
      end
    endcase
    write_window(xl, xh, yl, yh, $urandom_range(2) == 0,
                 CFG_IDX_WIDTH'($urandom_range(CFG_BAD_INDEX, CFG_Y_MAX + 1)));
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
        send_segment(make_segment(scale));
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      hold = ($urandom_range(7) == 0);
      // a hold always lowers in_valid before it waits for the results to drain
      if (hold && gap == 0) gap = 1;
      if (gap != 0) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold) while (sb.pending() != 0) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) random_phase(ph);
    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
